// File: rtl/jlv_pkg.sv
package jlv_pkg;

  // Default width of the signed brace and bracket counters
  localparam int unsigned DEPTH_COUNT_BITS = 16;

  // Characters the checker reacts to
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Lengths of the two required quoted names, quotes included
  localparam logic [3:0] NAME_A_LEN = 4'd11;
  localparam logic [2:0] NAME_B_LEN = 3'd6;

  typedef enum logic [1:0] {
    VERDICT_VALID       = 2'd0,
    VERDICT_PARSE_ERROR = 2'd1,
    VERDICT_NOT_OBJECT  = 2'd2,
    VERDICT_MISSING     = 2'd3
  } verdict_t;

  // Per-message flags and name-match progress
  typedef struct packed {
    logic       past;        // leading whitespace is behind us
    logic       start_err;   // first non-blank byte was not an opener
    logic       brace_start; // first non-blank byte was an opening brace
    logic       in_quotes;
    logic       prior_bs;    // previous byte was a backslash
    logic       overflow;    // a depth counter ran out of range
    logic [3:0] prog_a;
    logic [2:0] prog_b;
    logic [1:0] seen;        // bit 0 first name, bit 1 second name
  } msg_flags_t;

  // Expected byte at each position of the first required name with its quotes
  function automatic logic [7:0] name_a_at(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = CH_QUOTE;
      4'd1:    ch = 8'h74; // t
      4'd2:    ch = 8'h61; // a
      4'd3:    ch = 8'h73; // s
      4'd4:    ch = 8'h6B; // k
      4'd5:    ch = 8'h5F; // _
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h79; // y
      4'd8:    ch = 8'h70; // p
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = CH_QUOTE;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  // Expected byte at each position of "file" with its quotes
  function automatic logic [7:0] name_b_at(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = CH_QUOTE;
      3'd1:    ch = 8'h66; // f
      3'd2:    ch = 8'h69; // i
      3'd3:    ch = 8'h6C; // l
      3'd4:    ch = 8'h65; // e
      3'd5:    ch = CH_QUOTE;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

// File: rtl/json_light_validator_core.sv
// Streaming JSON shape checker. Bytes of a message enter on the in_ channel,
// one item per clock; the item with in_final_req set ends the message and
// yields one verdict on the out_ channel (0 valid, 1 parse error, 2 not an
// object, 3 a required quoted name missing). A zero byte without final is
// ignored; a zero byte with final only ends the message. The block sustains
// one item per cycle while the input does not stall: each byte is registered,
// then applied to the message state by a single pass of compare and counter
// logic. A verdict is written to the output register as its final byte leaves
// the input register. A final byte waits in the input register only while an
// earlier verdict is still untaken in the output register, and the input
// stalls behind it; otherwise the input never stalls. cfg_task_mode (always
// ready) is meant to be written between messages.
module json_light_validator_core #(
  parameter int unsigned DEPTH_COUNT_BITS = jlv_pkg::DEPTH_COUNT_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_final_req,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_verdict,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_task_mode
);

  logic                        task_mode_r;
  logic                        s1_valid_r;
  logic [7:0]                  s1_byte_r;
  logic                        s1_final_r;
  logic                        s1_advance;
  jlv_pkg::msg_flags_t         flags_r;
  jlv_pkg::msg_flags_t         flags_nxt;
  logic [DEPTH_COUNT_BITS-1:0] brace_r;
  logic [DEPTH_COUNT_BITS-1:0] brace_nxt;
  logic [DEPTH_COUNT_BITS-1:0] bracket_r;
  logic [DEPTH_COUNT_BITS-1:0] bracket_nxt;
  jlv_pkg::verdict_t           verdict;
  logic                        out_valid_r;
  jlv_pkg::verdict_t           out_verdict_r;

  // Hold a final byte until the output side can take its verdict
  assign s1_advance = s1_valid_r && (!s1_final_r || !out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_advance;
  assign cfg_ready  = 1'b1;

  // Write the mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      task_mode_r <= cfg_task_mode;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r  <= in_text_byte;
      s1_final_r <= in_final_req;
    end
  end

  jlv_step #(
    .DEPTH_COUNT_BITS(DEPTH_COUNT_BITS)
  ) u_step (
    .text_byte   (s1_byte_r),
    .final_req   (s1_final_r),
    .task_mode   (task_mode_r),
    .flags_cur   (flags_r),
    .brace_cur   (brace_r),
    .bracket_cur (bracket_r),
    .flags_nxt   (flags_nxt),
    .brace_nxt   (brace_nxt),
    .bracket_nxt (bracket_nxt),
    .verdict     (verdict)
  );

  // Advance the message state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r   <= '0;
      brace_r   <= '0;
      bracket_r <= '0;
    end else if (s1_advance) begin
      flags_r   <= flags_nxt;
      brace_r   <= brace_nxt;
      bracket_r <= bracket_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance && s1_final_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_final_r) begin
      out_verdict_r <= verdict;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

  // A stall comes only from a final byte meeting an untaken verdict
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s1_final_r && out_valid_r))
    else $error("input stalled without a pending verdict");

  // The end of a message leaves the counts cleared
  a_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_advance && s1_final_r) |=> (brace_r == '0 && bracket_r == '0 &&
                                     flags_r == '0))
    else $error("message state not cleared after verdict");

  // A start error can only follow the end of leading whitespace
  a_start_err_past: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.start_err |-> flags_r.past)
    else $error("start error without a start byte");

  // Name matchers never reach the full name length in state
  a_prog_range: assert property (@(posedge clk) disable iff (!rst_n)
    (flags_r.prog_a < jlv_pkg::NAME_A_LEN) && (flags_r.prog_b < jlv_pkg::NAME_B_LEN))
    else $error("name match progress out of range");

endmodule

// File: rtl/jlv_step.sv
module jlv_step #(
  parameter int unsigned DEPTH_COUNT_BITS = jlv_pkg::DEPTH_COUNT_BITS
) (
  input  logic [7:0]                   text_byte,
  input  logic                         final_req,
  input  logic                         task_mode,
  input  jlv_pkg::msg_flags_t          flags_cur,
  input  logic [DEPTH_COUNT_BITS-1:0]  brace_cur,
  input  logic [DEPTH_COUNT_BITS-1:0]  bracket_cur,
  output jlv_pkg::msg_flags_t          flags_nxt,
  output logic [DEPTH_COUNT_BITS-1:0]  brace_nxt,
  output logic [DEPTH_COUNT_BITS-1:0]  bracket_nxt,
  output jlv_pkg::verdict_t            verdict
);

  localparam logic [DEPTH_COUNT_BITS-1:0] CNT_MAX = {1'b0, {(DEPTH_COUNT_BITS-1){1'b1}}};
  localparam logic [DEPTH_COUNT_BITS-1:0] CNT_MIN = {1'b1, {(DEPTH_COUNT_BITS-1){1'b0}}};
  localparam logic [DEPTH_COUNT_BITS-1:0] CNT_ONE = {{(DEPTH_COUNT_BITS-1){1'b0}}, 1'b1};

  jlv_pkg::msg_flags_t         f;
  logic [DEPTH_COUNT_BITS-1:0] b;
  logic [DEPTH_COUNT_BITS-1:0] k;
  logic                        go;
  logic                        blank;
  logic [3:0]                  pa;
  logic [2:0]                  pb;

  assign blank = (text_byte == jlv_pkg::CH_SPACE) ||
                 (text_byte >= jlv_pkg::CH_TAB && text_byte <= jlv_pkg::CH_CR);

  // Apply one byte to the message state
  always_comb begin
    f  = flags_cur;
    b  = brace_cur;
    k  = bracket_cur;
    go = 1'b0;
    pa = 4'd0;
    pb = 3'd0;
    if (text_byte != jlv_pkg::CH_NUL) begin
      // Advance the two name matchers over every nonzero byte
      if (text_byte == jlv_pkg::name_a_at(flags_cur.prog_a)) begin
        pa = flags_cur.prog_a + 4'd1;
      end else if (text_byte == jlv_pkg::CH_QUOTE) begin
        pa = 4'd1;
      end
      if (pa == jlv_pkg::NAME_A_LEN) begin
        f.seen[0] = 1'b1;
        pa = 4'd0;
      end
      f.prog_a = pa;
      if (text_byte == jlv_pkg::name_b_at(flags_cur.prog_b)) begin
        pb = flags_cur.prog_b + 3'd1;
      end else if (text_byte == jlv_pkg::CH_QUOTE) begin
        pb = 3'd1;
      end
      if (pb == jlv_pkg::NAME_B_LEN) begin
        f.seen[1] = 1'b1;
        pb = 3'd0;
      end
      f.prog_b = pb;

      // Skip leading blanks, then check the opener
      if (!f.start_err) begin
        go = 1'b1;
        if (!f.past) begin
          if (blank) begin
            go = 1'b0;
          end else begin
            f.past = 1'b1;
            if (text_byte != jlv_pkg::CH_LBRACE && text_byte != jlv_pkg::CH_LBRACK) begin
              f.start_err = 1'b1;
              go = 1'b0;
            end else begin
              f.brace_start = (text_byte == jlv_pkg::CH_LBRACE);
              f.prior_bs = 1'b0;
            end
          end
        end
      end

      // Track quoting and move the depth counts, holding at the range ends
      if (go) begin
        if (text_byte == jlv_pkg::CH_QUOTE && !f.prior_bs) begin
          f.in_quotes = !f.in_quotes;
        end
        if (!f.in_quotes) begin
          if (text_byte == jlv_pkg::CH_LBRACE) begin
            if (b == CNT_MAX) f.overflow = 1'b1;
            else              b = b + CNT_ONE;
          end
          if (text_byte == jlv_pkg::CH_RBRACE) begin
            if (b == CNT_MIN) f.overflow = 1'b1;
            else              b = b - CNT_ONE;
          end
          if (text_byte == jlv_pkg::CH_LBRACK) begin
            if (k == CNT_MAX) f.overflow = 1'b1;
            else              k = k + CNT_ONE;
          end
          if (text_byte == jlv_pkg::CH_RBRACK) begin
            if (k == CNT_MIN) f.overflow = 1'b1;
            else              k = k - CNT_ONE;
          end
        end
        f.prior_bs = (text_byte == jlv_pkg::CH_BSLASH);
      end
    end
  end

  // Judge the message as it stands after this byte
  always_comb begin
    priority if (!f.past || f.start_err || f.overflow ||
                 b != '0 || k != '0) begin
      verdict = jlv_pkg::VERDICT_PARSE_ERROR;
    end else if (task_mode && !f.brace_start) begin
      verdict = jlv_pkg::VERDICT_NOT_OBJECT;
    end else if (task_mode && f.seen != 2'b11) begin
      verdict = jlv_pkg::VERDICT_MISSING;
    end else begin
      verdict = jlv_pkg::VERDICT_VALID;
    end
  end

  // Clear everything once the message ends
  assign flags_nxt   = final_req ? '0 : f;
  assign brace_nxt   = final_req ? '0 : b;
  assign bracket_nxt = final_req ? '0 : k;

endmodule
